// File: sv/round_robin_thread_scheduler_core_defines.svh
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler_core_defines
// Assertion macros used by the scheduler back end (rrts_back).
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_CORE_DEFINES_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_CORE_DEFINES_SVH

// Check that a condition implies another in the same cycle
`define RRTS_ASSERT_IMPL(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error(msg);

// Check that a condition implies another in the next cycle
`define RRTS_ASSERT_NEXT(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error(msg);

`endif

// File: sv/rrts_pkg.sv
// ----------------------------------------------------------------------------
// rrts_pkg
// Types and constants of the round-robin thread scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

    localparam int MaxThreads = 16;
    localparam int IdW = $clog2(MaxThreads);
    localparam int CntW = $clog2(MaxThreads + 1);
    localparam int QDepth = 2;

    localparam logic [2:0] CMD_TICK = 3'd0;
    localparam logic [2:0] CMD_CREATE = 3'd1;
    localparam logic [2:0] CMD_START = 3'd2;
    localparam logic [2:0] CMD_TERM = 3'd3;
    localparam logic [2:0] CMD_DESTROY = 3'd4;
    localparam logic [2:0] CMD_QUERY = 3'd5;

    localparam logic [2:0] ST_FREE = 3'd0;
    localparam logic [2:0] ST_WAIT = 3'd1;
    localparam logic [2:0] ST_READY = 3'd2;
    localparam logic [2:0] ST_RUN = 3'd3;
    localparam logic [2:0] ST_TERM = 3'd4;

    localparam logic [1:0] STS_OK = 2'd0;
    localparam logic [1:0] STS_FULL = 2'd1;
    localparam logic [1:0] STS_BAD = 2'd2;
    localparam logic [1:0] STS_LAST = 2'd3;

    // Command word as classified by the front end
    typedef struct packed {
        logic [2:0]  cmd;
        logic [3:0]  tid;
        logic [31:0] entry_addr;
        logic        bad_cmd;
    } cmd_word_t;

    // Result word
    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  result_id;
        logic [2:0]  thr_state;
        logic        switched;
        logic        first_run;
        logic [3:0]  running_id;
        logic [31:0] running_entry_addr;
        logic [7:0]  quantum_left;
    } res_word_t;

endpackage

// File: sv/rrts_front.sv
// ----------------------------------------------------------------------------
// rrts_front
// Accepts command words, flags unknown codes and queues them for the back end.
// ----------------------------------------------------------------------------
module rrts_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_cmd,
    input  logic [3:0]          s_tid,
    input  logic [31:0]         s_entry_addr,
    output logic                q_valid,
    input  logic                q_ready,
    output rrts_pkg::cmd_word_t q_word
);
    import rrts_pkg::*;

    localparam int PtrW = $clog2(QDepth);

    cmd_word_t          mem_reg [QDepth];
    logic [PtrW-1:0]    wr_reg, wr_next, rd_reg, rd_next;
    logic [PtrW:0]      cnt_reg, cnt_next;
    cmd_word_t          in_word;
    logic               push, pop;

    // Classify the incoming word
    always_comb begin
        in_word.cmd = s_cmd;
        in_word.tid = s_tid;
        in_word.entry_addr = s_entry_addr;
        in_word.bad_cmd = (s_cmd > CMD_QUERY);
    end

    assign s_ready = (cnt_reg != (PtrW+1)'(QDepth));
    assign q_valid = (cnt_reg != '0);
    assign q_word  = mem_reg[rd_reg];
    assign push = s_valid && s_ready;
    assign pop  = q_valid && q_ready;

    // Advance pointers
    always_comb begin
        wr_next = push ? wr_reg + 1'b1 : wr_reg;
        rd_next = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg <= wr_next;
            rd_reg <= rd_next;
            cnt_reg <= cnt_next;
        end
        if (push) begin
            mem_reg[wr_reg] <= in_word;
        end
    end

endmodule

// File: sv/rrts_back.sv
// ----------------------------------------------------------------------------
// rrts_back
// Executes one command at a time against the thread table and active order.
// ----------------------------------------------------------------------------
module rrts_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [7:0]          quantum,
    input  logic                q_valid,
    output logic                q_ready,
    input  rrts_pkg::cmd_word_t q_word,
    output logic                m_valid,
    input  logic                m_ready,
    output rrts_pkg::res_word_t m_word
);
    import rrts_pkg::*;
    `include "round_robin_thread_scheduler_core_defines.svh"

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_ALLOC, S_REMOVE, S_ROTATE, S_FINISH
    } state_t;

    state_t         state_reg;
    logic [2:0]     tst_reg [MaxThreads];
    logic [31:0]    task_reg [MaxThreads];
    logic [IdW-1:0] ord_reg [MaxThreads];
    logic [CntW-1:0] acnt_reg;
    logic [7:0]     ticks_reg;
    logic [IdW-1:0] cur_reg;
    cmd_word_t      w_reg;
    logic [CntW-1:0] idx_reg;
    logic [CntW-1:0] pos_reg;
    logic           found_reg;
    logic           freeit_reg;
    logic           sw_reg, fr_reg;
    logic [1:0]     sts_reg;
    logic [3:0]     rid_reg;
    logic           rep_reg;
    logic           out_v_reg;
    res_word_t      out_reg;
    logic [IdW-1:0] nxt_reg;

    assign q_ready = (state_reg == S_IDLE) && !out_v_reg;
    assign m_valid = out_v_reg;
    assign m_word = out_reg;

    // Sequencer: scan, allocate, remove and rotate one entry per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            out_v_reg <= 1'b0;
            for (int i = 0; i < MaxThreads; i++) begin
                tst_reg[i] <= (i == 0) ? ST_RUN : ST_FREE;
                ord_reg[i] <= '0;
            end
            task_reg[0] <= '0;
            acnt_reg <= CntW'(1);
            ticks_reg <= '0;
            cur_reg <= '0;
        end else begin
            if (out_v_reg && m_ready) begin
                out_v_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (q_valid && !out_v_reg) begin
                        logic [1:0]      sts;
                        logic [3:0]      rid;
                        logic            rep;
                        logic            frees;
                        logic [CntW-1:0] idx;
                        state_t          nst;
                        sts = STS_OK;
                        rid = q_word.tid;
                        rep = 1'b1;
                        frees = 1'b0;
                        idx = '0;
                        nst = S_FINISH;
                        if (q_word.bad_cmd) begin
                            sts = STS_BAD;
                            rid = '0;
                            rep = 1'b0;
                        end else begin
                            case (q_word.cmd)
                                CMD_TICK: begin
                                    rid = '0;
                                    rep = 1'b0;
                                    if (acnt_reg > CntW'(1) && ticks_reg <= 8'd1) begin
                                        ticks_reg <= '0;
                                        tst_reg[ord_reg[0]] <= ST_READY;
                                        // Save the last entry before the shift overwrites it
                                        nxt_reg <= ord_reg[acnt_reg[IdW-1:0] - 1'b1];
                                        idx = acnt_reg - 1'b1;
                                        nst = S_ROTATE;
                                    end else if (ticks_reg != '0) begin
                                        ticks_reg <= ticks_reg - 1'b1;
                                    end
                                end
                                CMD_CREATE: begin
                                    nst = S_ALLOC;
                                end
                                CMD_START, CMD_TERM: begin
                                    nst = S_SCAN;
                                end
                                CMD_DESTROY: begin
                                    if (tst_reg[q_word.tid] == ST_FREE) begin
                                        sts = STS_BAD;
                                    end else begin
                                        frees = 1'b1;
                                        nst = S_SCAN;
                                    end
                                end
                                default: begin
                                end
                            endcase
                        end
                        w_reg <= q_word;
                        sw_reg <= 1'b0;
                        fr_reg <= 1'b0;
                        sts_reg <= sts;
                        rid_reg <= rid;
                        rep_reg <= rep;
                        idx_reg <= idx;
                        found_reg <= 1'b0;
                        freeit_reg <= frees;
                        state_reg <= nst;
                    end
                end
                // Look up the addressed id in the active order
                S_SCAN: begin
                    if (idx_reg < acnt_reg && ord_reg[idx_reg[IdW-1:0]] == w_reg.tid
                        && !found_reg) begin
                        found_reg <= 1'b1;
                        pos_reg <= idx_reg;
                    end
                    if (idx_reg == CntW'(MaxThreads - 1)) begin
                        state_reg <= S_FINISH;
                        if (w_reg.cmd == CMD_START) begin
                            if (tst_reg[w_reg.tid] != ST_WAIT || found_reg
                                || (idx_reg < acnt_reg
                                    && ord_reg[idx_reg[IdW-1:0]] == w_reg.tid)
                                || acnt_reg >= CntW'(MaxThreads)) begin
                                sts_reg <= STS_BAD;
                            end else begin
                                ord_reg[acnt_reg[IdW-1:0]] <= w_reg.tid;
                                acnt_reg <= acnt_reg + 1'b1;
                            end
                        end else begin
                            logic        fnd;
                            logic [CntW-1:0] p;
                            fnd = found_reg || (idx_reg < acnt_reg
                                && ord_reg[idx_reg[IdW-1:0]] == w_reg.tid);
                            p = found_reg ? pos_reg : idx_reg;
                            if (!fnd) begin
                                if (w_reg.cmd == CMD_TERM) begin
                                    sts_reg <= STS_BAD;
                                end else begin
                                    tst_reg[w_reg.tid] <= ST_FREE;
                                end
                            end else if (p == '0) begin
                                if (acnt_reg < CntW'(2)) begin
                                    sts_reg <= STS_LAST;
                                end else begin
                                    tst_reg[w_reg.tid] <= ST_TERM;
                                    sw_reg <= 1'b1;
                                    idx_reg <= '0;
                                    state_reg <= S_REMOVE;
                                end
                            end else begin
                                tst_reg[w_reg.tid] <= ST_TERM;
                                idx_reg <= p;
                                state_reg <= S_REMOVE;
                            end
                        end
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                // Next-fit search for a free id
                S_ALLOC: begin
                    logic [IdW-1:0] a;
                    a = cur_reg + idx_reg[IdW-1:0];
                    if (tst_reg[a] == ST_FREE) begin
                        cur_reg <= a;
                        tst_reg[a] <= ST_WAIT;
                        task_reg[a] <= w_reg.entry_addr;
                        rid_reg <= a;
                        state_reg <= S_FINISH;
                    end else if (idx_reg == CntW'(MaxThreads - 1)) begin
                        sts_reg <= STS_FULL;
                        rid_reg <= '0;
                        rep_reg <= 1'b0;
                        state_reg <= S_FINISH;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                // Close the gap one entry per cycle
                S_REMOVE: begin
                    if (idx_reg + 1'b1 >= acnt_reg) begin
                        acnt_reg <= acnt_reg - 1'b1;
                        if (sw_reg) begin
                            // Save the new last entry before rotating
                            nxt_reg <= ord_reg[acnt_reg[IdW-1:0] - IdW'(2)];
                            idx_reg <= acnt_reg - CntW'(2);
                            state_reg <= S_ROTATE;
                        end else begin
                            state_reg <= S_FINISH;
                        end
                    end else begin
                        ord_reg[idx_reg[IdW-1:0]] <= ord_reg[idx_reg[IdW-1:0] + 1'b1];
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                // Shift the order down and bring the saved last entry to the front
                S_ROTATE: begin
                    if (idx_reg == '0) begin
                        ord_reg[0] <= nxt_reg;
                        ticks_reg <= quantum;
                        sw_reg <= 1'b1;
                        if (tst_reg[nxt_reg] == ST_WAIT) begin
                            fr_reg <= 1'b1;
                            tst_reg[nxt_reg] <= ST_RUN;
                        end else if (tst_reg[nxt_reg] == ST_READY) begin
                            tst_reg[nxt_reg] <= ST_RUN;
                        end
                        state_reg <= S_FINISH;
                    end else begin
                        ord_reg[idx_reg[IdW-1:0]] <= ord_reg[idx_reg[IdW-1:0] - 1'b1];
                        idx_reg <= idx_reg - 1'b1;
                    end
                end
                // Free the id if destroying, then register the result word
                S_FINISH: begin
                    logic [2:0] ts;
                    ts = tst_reg[rid_reg];
                    if (freeit_reg && sts_reg == STS_OK) begin
                        tst_reg[w_reg.tid] <= ST_FREE;
                        ts = ST_FREE;
                    end
                    out_reg.status <= sts_reg;
                    out_reg.result_id <= rid_reg;
                    out_reg.thr_state <= rep_reg ? ts : 3'd0;
                    out_reg.switched <= sw_reg;
                    out_reg.first_run <= sw_reg && fr_reg;
                    out_reg.running_id <= ord_reg[0];
                    out_reg.running_entry_addr <= task_reg[ord_reg[0]];
                    out_reg.quantum_left <= ticks_reg;
                    out_v_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `RRTS_ASSERT_IMPL(a_cnt_range, aclk, aresetn, 1'b1,
        (acnt_reg != '0 && acnt_reg <= CntW'(MaxThreads)), "active count out of range")
    `RRTS_ASSERT_IMPL(a_fr_sw, aclk, aresetn, m_valid, (!m_word.first_run || m_word.switched),
        "first run without switch")
    `RRTS_ASSERT_NEXT(a_finish, aclk, aresetn, (state_reg == S_FINISH), m_valid,
        "result not posted after finish")

endmodule

// File: sv/round_robin_thread_scheduler_core.sv
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler_core
// Thread table with round-robin scheduling and a time quantum.
// ----------------------------------------------------------------------------
// Channel   Dir  Ports
// s_        in   s_valid s_ready s_cmd s_tid s_entry_addr
// m_        out  m_valid m_ready m_status .. m_quantum_left
// cfg       in   cfg_valid cfg_ready cfg_data (quantum)
//
// One command at a time in the back end, behind a two-word queue. Query and
// plain tick post directly; a rotating tick rotates the active order; create
// searches for a free id; start scans; terminate and destroy scan, shift and may
// rotate (scan, shift and rotate of the 16-entry order, one entry per cycle).
// Input stalls while the queue is full; a posted result holds until m_ready.
// Reset synchronous, active low: thread 0 running, quantum 10.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_cmd,
    input  logic [3:0]  s_tid,
    input  logic [31:0] s_entry_addr,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [3:0]  m_result_id,
    output logic [2:0]  m_thr_state,
    output logic        m_switched,
    output logic        m_first_run,
    output logic [3:0]  m_running_id,
    output logic [31:0] m_running_entry_addr,
    output logic [7:0]  m_quantum_left,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);
    import rrts_pkg::*;

    logic       q_valid, q_ready;
    cmd_word_t  q_word;
    res_word_t  r_word;
    logic [7:0] quantum_reg;

    // Hold the quantum register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quantum_reg <= 8'd10;
        end else if (cfg_valid) begin
            quantum_reg <= cfg_data;
        end
    end

    rrts_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .s_tid(s_tid), .s_entry_addr(s_entry_addr),
        .q_valid(q_valid), .q_ready(q_ready), .q_word(q_word)
    );

    rrts_back u_back (
        .aclk(aclk), .aresetn(aresetn), .quantum(quantum_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_word(q_word),
        .m_valid(m_valid), .m_ready(m_ready), .m_word(r_word)
    );

    assign m_status = r_word.status;
    assign m_result_id = r_word.result_id;
    assign m_thr_state = r_word.thr_state;
    assign m_switched = r_word.switched;
    assign m_first_run = r_word.first_run;
    assign m_running_id = r_word.running_id;
    assign m_running_entry_addr = r_word.running_entry_addr;
    assign m_quantum_left = r_word.quantum_left;

endmodule
